@@ sv/nec_pkg.sv @@
// ----------------------------------------------------------------------------
// nec_pkg: shared constants for the NEC IR pulse decoder
// Field widths, opcode and mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package nec_pkg;

	localparam int DURATION_BITS_DEF = 16;

	localparam int DUR_W   = 16;
	localparam int TMO_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int BITPOS_W = 3;
	localparam int OP_W    = 2;
	localparam int MODE_W  = 2;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	localparam logic [BITPOS_W-1:0] LAST_BIT = 3'd7;

	// opcodes
	localparam logic [OP_W-1:0] OP_FALL = 2'd0;
	localparam logic [OP_W-1:0] OP_RISE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	// decoder modes
	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RECEIVE = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_START_HIGH = 3'd0;
	localparam logic [CIDX_W-1:0] REG_START_LOW  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MARK       = 3'd2;
	localparam logic [CIDX_W-1:0] REG_ZERO_SPACE = 3'd3;
	localparam logic [CIDX_W-1:0] REG_ONE_SPACE  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_TOLERANCE  = 3'd5;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT    = 3'd6;

	// register reset values
	localparam logic [DUR_W-1:0] RST_START_HIGH = 16'd9000;
	localparam logic [DUR_W-1:0] RST_START_LOW  = 16'd4500;
	localparam logic [DUR_W-1:0] RST_MARK       = 16'd562;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd562;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 16'd1687;
	localparam logic [DUR_W-1:0] RST_TOLERANCE  = 16'd200;
	localparam logic [TMO_W-1:0] RST_TIMEOUT    = 8'd20;

endpackage

@@ sv/nec_if.sv @@
// ----------------------------------------------------------------------------
// nec_if: valid/ready channels of the NEC IR pulse decoder
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface nec_item_if;
	logic                        valid;
	logic                        ready;
	logic [nec_pkg::OP_W-1:0]    opcode;
	logic [nec_pkg::DUR_W-1:0]   phase_len;

	modport source (output valid, output opcode, output phase_len, input ready);
	modport sink   (input valid, input opcode, input phase_len, output ready);
endinterface

interface nec_result_if;
	logic                         valid;
	logic                         ready;
	logic                         byte_valid;
	logic [nec_pkg::BYTE_W-1:0]   byte_data;
	logic [nec_pkg::MODE_W-1:0]   decoder_state;

	modport source (output valid, output byte_valid, output byte_data,
		output decoder_state, input ready);
	modport sink   (input valid, input byte_valid, input byte_data,
		input decoder_state, output ready);
endinterface

interface nec_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [nec_pkg::CIDX_W-1:0]    index;
	logic [nec_pkg::CDATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/nec_ir_pulse_decoder.sv @@
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder: NEC-style infrared pulse decoder
// Checks the start burst, decodes bits from mark/space lengths, emits bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item_in  - one transfer per IR line edge (falling or rising, with the
//              length in us of the phase that just ended) or per 1 ms tick.
//   result   - exactly one transfer per input item: byte_valid/byte_data
//              when the item completed a byte (MSB first), plus the decoder
//              state after the item.
//   cfg      - register writes (index, data); always ready. Write only while
//              no item is in flight.
// Pipeline: an accepted item is held in the input register; its result is
//   loaded into the result register when that can load and is presented
//   until taken. Throughput: one item per cycle while results are taken,
//   set by the single compare/update pass between the two registers.
// Stall: when the result is not taken, the result register holds, the input
//   register fills, and item_in.ready drops; nothing is lost.
// Reset (arst_n low): decoder idle, byte and bit count cleared, timeout
//   disarmed, all timing registers back to their NEC defaults.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder #(
	parameter int DURATION_BITS = nec_pkg::DURATION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	nec_item_if.sink             item_in,
	nec_result_if.source         result,
	nec_cfg_if.sink              cfg
);

	localparam int DW = nec_pkg::DUR_W;
	// only the low DURATION_BITS bits of a length count
	localparam logic [DW-1:0] DUR_MASK = (DURATION_BITS >= DW) ? {DW{1'b1}} :
		DW'((64'd1 << DURATION_BITS) - 64'd1);

	// ---------------- configuration registers ----------------
	logic [DW-1:0]                start_high_q, start_low_q, mark_q;
	logic [DW-1:0]                zero_space_q, one_space_q, tolerance_q;
	logic [nec_pkg::TMO_W-1:0]    timeout_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_high_q <= nec_pkg::RST_START_HIGH;
			start_low_q  <= nec_pkg::RST_START_LOW;
			mark_q       <= nec_pkg::RST_MARK;
			zero_space_q <= nec_pkg::RST_ZERO_SPACE;
			one_space_q  <= nec_pkg::RST_ONE_SPACE;
			tolerance_q  <= nec_pkg::RST_TOLERANCE;
			timeout_q    <= nec_pkg::RST_TIMEOUT;
		end else if (cfg.valid) begin
			case (cfg.index)
				nec_pkg::REG_START_HIGH: start_high_q <= cfg.data;
				nec_pkg::REG_START_LOW:  start_low_q  <= cfg.data;
				nec_pkg::REG_MARK:       mark_q       <= cfg.data;
				nec_pkg::REG_ZERO_SPACE: zero_space_q <= cfg.data;
				nec_pkg::REG_ONE_SPACE:  one_space_q  <= cfg.data;
				nec_pkg::REG_TOLERANCE:  tolerance_q  <= cfg.data;
				nec_pkg::REG_TIMEOUT:    timeout_q    <= cfg.data[nec_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                         valid_s1;
	logic [nec_pkg::OP_W-1:0]     opcode_s1;
	logic [DW-1:0]                dur_s1;
	logic                         advance;   // result register can load

	assign advance       = !result.valid || result.ready;
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			opcode_s1 <= item_in.opcode;
			dur_s1    <= item_in.phase_len & DUR_MASK;
		end
	end

	// ---------------- decoder state ----------------
	logic [nec_pkg::MODE_W-1:0]   mode_q;
	logic [nec_pkg::BYTE_W-1:0]   partial_q;
	logic [nec_pkg::BITPOS_W-1:0] bitpos_q;
	logic                         armed_q;
	logic [nec_pkg::TMO_W-1:0]    left_q;

	// |a - b| < tolerance
	function automatic logic near(input logic [DW-1:0] got, input logic [DW-1:0] want,
		input logic [DW-1:0] tol);
		logic [DW-1:0] d;
		begin
			d = (got > want) ? (got - want) : (want - got);
			near = d < tol;
		end
	endfunction

	logic near_sh, near_sl, near_mark, near_zero, near_one;
	assign near_sh   = near(dur_s1, start_high_q, tolerance_q);
	assign near_sl   = near(dur_s1, start_low_q, tolerance_q);
	assign near_mark = near(dur_s1, mark_q, tolerance_q);
	assign near_zero = near(dur_s1, zero_space_q, tolerance_q);
	assign near_one  = near(dur_s1, one_space_q, tolerance_q);

	logic [nec_pkg::MODE_W-1:0]   mode_d;
	logic [nec_pkg::BYTE_W-1:0]   partial_d, shifted;
	logic [nec_pkg::BITPOS_W-1:0] bitpos_d;
	logic                         armed_d;
	logic [nec_pkg::TMO_W-1:0]    left_d;
	logic                         bval_d;
	logic [nec_pkg::BYTE_W-1:0]   bdata_d;
	logic                         take, bit_val;

	// bit lands at position 7 - bitpos (MSB first)
	assign bit_val = !near_zero;   // zero wins when both spaces match
	assign shifted = partial_q |
		(nec_pkg::BYTE_W'(bit_val) << (nec_pkg::LAST_BIT - bitpos_q));

	always_comb begin
		mode_d    = mode_q;
		partial_d = partial_q;
		bitpos_d  = bitpos_q;
		armed_d   = armed_q;
		left_d    = left_q;
		bval_d    = 1'b0;
		bdata_d   = '0;
		take      = 1'b0;
		case (opcode_s1)
			nec_pkg::OP_FALL: begin
				case (mode_q)
					nec_pkg::MODE_START: begin
						if (!near_sh) mode_d = nec_pkg::MODE_IDLE;
					end
					nec_pkg::MODE_RECEIVE: begin
						if (near_mark) begin
							armed_d = 1'b1;
							left_d  = timeout_q;
						end else begin
							mode_d = nec_pkg::MODE_IDLE;
						end
					end
					default: mode_d = nec_pkg::MODE_IDLE;
				endcase
			end
			nec_pkg::OP_RISE: begin
				case (mode_q)
					nec_pkg::MODE_START: begin
						if (near_sl) begin
							partial_d = '0;
							bitpos_d  = '0;
							mode_d    = nec_pkg::MODE_RECEIVE;
						end else begin
							mode_d = nec_pkg::MODE_IDLE;
						end
					end
					nec_pkg::MODE_RECEIVE: begin
						if (near_zero || near_one) take = 1'b1;
						else mode_d = nec_pkg::MODE_IDLE;
					end
					default: mode_d = nec_pkg::MODE_START;
				endcase
			end
			nec_pkg::OP_TICK: begin
				if (armed_q) begin
					if (left_q <= nec_pkg::TMO_W'(1)) begin
						armed_d = 1'b0;
						left_d  = '0;
						if (mode_q == nec_pkg::MODE_RECEIVE) mode_d = nec_pkg::MODE_IDLE;
					end else begin
						left_d = left_q - nec_pkg::TMO_W'(1);
					end
				end
			end
			default: ;
		endcase

		// a decoded bit disarms the timeout and may close the byte
		if (take) begin
			armed_d = 1'b0;
			left_d  = '0;
			if (bitpos_q == nec_pkg::LAST_BIT) begin
				bval_d    = 1'b1;
				bdata_d   = shifted;
				partial_d = '0;
				bitpos_d  = '0;
			end else begin
				partial_d = shifted;
				bitpos_d  = bitpos_q + nec_pkg::BITPOS_W'(1);
			end
		end
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= nec_pkg::MODE_IDLE;
			partial_q <= '0;
			bitpos_q  <= '0;
			armed_q   <= 1'b0;
			left_q    <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			partial_q <= partial_d;
			bitpos_q  <= bitpos_d;
			armed_q   <= armed_d;
			left_q    <= left_d;
		end
	end

	// ---------------- result register ----------------
	logic                         res_valid_q;
	logic                         bval_q;
	logic [nec_pkg::BYTE_W-1:0]   bdata_q;
	logic [nec_pkg::MODE_W-1:0]   state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			bval_q  <= bval_d;
			bdata_q <= bdata_d;
			state_q <= mode_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.byte_valid    = bval_q;
	assign result.byte_data     = bdata_q;
	assign result.decoder_state = state_q;

endmodule
